// File: src/palette_alpha_blend_nearest_defines.svh
// Assertion macros shared by the palette blend RTL.
`ifndef PALETTE_ALPHA_BLEND_NEAREST_DEFINES_SVH
`define PALETTE_ALPHA_BLEND_NEAREST_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PAB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PAB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/pab_pkg.sv
package pab_pkg;

	// request kinds, carried on s_tuser
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_BLEND   = 2'd1;
	localparam logic [OP_W-1:0] OP_NEAREST = 2'd2;

	localparam int COLOR_W   = 8;
	localparam int INDEX_W   = 8;
	localparam int LEVEL_W   = 3;
	localparam int CELL_W    = 5;
	localparam int PROD_W    = 2 * COLOR_W;
	localparam int DIST_W    = 18;
	localparam int LUT_DEPTH = 1 << INDEX_W;

	// s_tdata field offsets, lowest bit first
	localparam int IN_INDEX_LSB = 0;
	localparam int IN_DST_LSB   = IN_INDEX_LSB + INDEX_W;
	localparam int IN_LEVEL_LSB = IN_DST_LSB + INDEX_W;
	localparam int IN_RED_LSB   = IN_LEVEL_LSB + LEVEL_W;
	localparam int IN_GREEN_LSB = IN_RED_LSB + COLOR_W;
	localparam int IN_BLUE_LSB  = IN_GREEN_LSB + COLOR_W;
	localparam int IN_DATA_W    = 48;
	localparam int OUT_DATA_W   = 8;

	typedef struct packed {
		logic [COLOR_W-1:0] b;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] r;
	} rgb_t;

	typedef struct packed {
		logic [CELL_W-1:0] b;
		logic [CELL_W-1:0] g;
		logic [CELL_W-1:0] r;
	} cell_t;

endpackage

// File: src/palette_alpha_blend_nearest.sv
// A palette write is accepted in the idle state, one request per cycle while the block is idle.
// Nearest query: the winner is loaded into the output register once that register is free,
// and no new request is taken until then. Blend adds two palette reads (source, then destination).
// Throughput is set by the search, one palette entry per cycle through the single read port.
// Reset (arst_n low, async) clears control and the output register; palette contents are
// undefined until written.
`include "palette_alpha_blend_nearest_defines.svh"

module palette_alpha_blend_nearest
	import pab_pkg::*;
#(
	parameter int PALETTE_SIZE = 256,
	parameter int ALPHA_STEPS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [7:0] index, [15:8] dst_index, [18:16] blend_level, [26:19] red,
	// [34:27] green, [42:35] blue, [47:43] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [7:0] color_index
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_SIZE - 2);
	localparam int N_LEVELS = 1 << LEVEL_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_DST,
		ST_MIX,
		ST_SEARCH,
		ST_DRAIN
	} state_t;

	state_t state_q;

	// ---------------------------------------------------------------
	// Request fields
	// ---------------------------------------------------------------
	logic [INDEX_W-1:0] in_index, in_dst;
	logic [LEVEL_W-1:0] in_level;
	rgb_t               in_rgb;

	assign in_index = s_tdata[IN_INDEX_LSB +: INDEX_W];
	assign in_dst   = s_tdata[IN_DST_LSB +: INDEX_W];
	assign in_level = s_tdata[IN_LEVEL_LSB +: LEVEL_W];
	assign in_rgb.r = s_tdata[IN_RED_LSB +: COLOR_W];
	assign in_rgb.g = s_tdata[IN_GREEN_LSB +: COLOR_W];
	assign in_rgb.b = s_tdata[IN_BLUE_LSB +: COLOR_W];

	// Index wrap (mod PALETTE_SIZE) and source weight, both folded to constant tables.
	logic [IDX_W-1:0]   wrap_lut  [LUT_DEPTH];
	logic [COLOR_W-1:0] alpha_lut [N_LEVELS];

	for (genvar k = 0; k < LUT_DEPTH; k++) begin : g_wrap
		assign wrap_lut[k] = IDX_W'(k % PALETTE_SIZE);
	end

	for (genvar l = 0; l < N_LEVELS; l++) begin : g_alpha
		localparam int LVL = (l >= ALPHA_STEPS) ? ALPHA_STEPS - 1 : l;
		assign alpha_lut[l] = COLOR_W'((LVL * 256) / ALPHA_STEPS);
	end

	logic accept;
	logic out_free;
	logic out_load;
	logic search_start;
	logic pipe_empty;

	assign s_tready     = (state_q == ST_IDLE);
	assign accept       = s_tvalid && s_tready;
	assign out_free     = !m_tvalid || m_tready;
	assign search_start = (accept && s_tuser == OP_NEAREST) || (state_q == ST_MIX);

	// ---------------------------------------------------------------
	// Palette memory: one write port, one registered read port
	// ---------------------------------------------------------------
	rgb_t             palette [PALETTE_SIZE];
	logic [IDX_W-1:0] rd_addr;
	rgb_t             rd_data_q;
	logic             wr_en;
	logic [IDX_W-1:0] dst_q;
	logic [IDX_W-1:0] cnt_q;

	assign wr_en = accept && (s_tuser == OP_WRITE);

	always_comb begin
		case (state_q)
			ST_IDLE:   rd_addr = wrap_lut[in_index];
			ST_RD_DST: rd_addr = dst_q;
			default:   rd_addr = cnt_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			palette[wrap_lut[in_index]] <= in_rgb;
		end
		rd_data_q <= palette[rd_addr];
	end

	// ---------------------------------------------------------------
	// Blend datapath: src products in RD_DST, dst products + sum in MIX
	// ---------------------------------------------------------------
	logic [COLOR_W-1:0] alpha_q;
	logic [PROD_W-1:0]  prod_r_q, prod_g_q, prod_b_q;
	logic [COLOR_W:0]   dst_wt;
	logic [PROD_W:0]    mix_r, mix_g, mix_b;
	cell_t              cell_q;

	assign dst_wt = (COLOR_W + 1)'(256) - {1'b0, alpha_q};
	assign mix_r  = {1'b0, prod_r_q} + (PROD_W + 1)'(rd_data_q.r * dst_wt);
	assign mix_g  = {1'b0, prod_g_q} + (PROD_W + 1)'(rd_data_q.g * dst_wt);
	assign mix_b  = {1'b0, prod_b_q} + (PROD_W + 1)'(rd_data_q.b * dst_wt);

	// ---------------------------------------------------------------
	// Search pipeline: s1 = read data, s2 = distance, then compare
	// ---------------------------------------------------------------
	logic               v_s1, v_s2;
	logic [IDX_W-1:0]   idx_s1, idx_s2;
	logic [DIST_W-1:0]  dist_s2;
	logic [DIST_W-1:0]  best_dist_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [COLOR_W-1:0] ctr_r, ctr_g, ctr_b;
	logic [COLOR_W-1:0] dr, dg, db;
	logic [DIST_W-1:0]  sq_dist;

	// cell centre: (q << 3) + 4
	assign ctr_r = {cell_q.r, 3'b100};
	assign ctr_g = {cell_q.g, 3'b100};
	assign ctr_b = {cell_q.b, 3'b100};
	assign dr = (ctr_r > rd_data_q.r) ? ctr_r - rd_data_q.r : rd_data_q.r - ctr_r;
	assign dg = (ctr_g > rd_data_q.g) ? ctr_g - rd_data_q.g : rd_data_q.g - ctr_g;
	assign db = (ctr_b > rd_data_q.b) ? ctr_b - rd_data_q.b : rd_data_q.b - ctr_b;
	assign sq_dist = DIST_W'(dr * dr) + DIST_W'(dg * dg) + DIST_W'(db * db);

	assign pipe_empty = !v_s1 && !v_s2;
	// search done and the output register free: hand the winner over
	assign out_load   = (state_q == ST_DRAIN) && pipe_empty && out_free;

	always_ff @(posedge clk) begin
		if (accept) begin
			dst_q   <= wrap_lut[in_dst];
			alpha_q <= alpha_lut[in_level];
			if (s_tuser == OP_NEAREST) begin
				cell_q <= '{b: in_rgb.b[COLOR_W-1 -: CELL_W],
					g: in_rgb.g[COLOR_W-1 -: CELL_W],
					r: in_rgb.r[COLOR_W-1 -: CELL_W]};
			end
		end
		if (state_q == ST_RD_DST) begin
			prod_r_q <= rd_data_q.r * alpha_q;
			prod_g_q <= rd_data_q.g * alpha_q;
			prod_b_q <= rd_data_q.b * alpha_q;
		end
		if (state_q == ST_MIX) begin
			// mixed channel is sum[15:8]; its top five bits pick the cell
			cell_q <= '{b: mix_b[PROD_W-1 -: CELL_W],
				g: mix_g[PROD_W-1 -: CELL_W],
				r: mix_r[PROD_W-1 -: CELL_W]};
		end
		idx_s1  <= cnt_q;
		idx_s2  <= idx_s1;
		dist_s2 <= sq_dist;
		// strict less-than keeps the lowest index on a tie
		if (search_start) begin
			best_dist_q <= '1;
		end else if (v_s2 && dist_s2 < best_dist_q) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= idx_s2;
		end
	end

	// ---------------------------------------------------------------
	// Control
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			v_s1 <= (state_q == ST_SEARCH);
			v_s2 <= v_s1;
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata  <= OUT_DATA_W'(best_idx_q);
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (s_tuser)
							OP_BLEND:   state_q <= ST_RD_DST;
							OP_NEAREST: state_q <= ST_SEARCH;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RD_DST: state_q <= ST_MIX;
				ST_MIX:    state_q <= ST_SEARCH;
				ST_SEARCH: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PAB_ASSERT_NOW(a_never_transparent, m_tvalid, m_tdata <= OUT_DATA_W'(PALETTE_SIZE - 2), "result is the transparent entry")
	`PAB_ASSERT_NOW(a_cnt_range, state_q == ST_SEARCH, cnt_q <= LAST_IDX, "search counter out of range")
	`PAB_ASSERT_NOW(a_pipe_in_search, v_s1 || v_s2, state_q == ST_SEARCH || state_q == ST_DRAIN, "search pipeline busy outside search")
	`PAB_ASSERT_NEXT(a_result_loaded, state_q == ST_DRAIN && pipe_empty && out_free, m_tvalid && state_q == ST_IDLE, "finished search not delivered")

endmodule
